// File: design/stl_pkg.sv
// ----------------------------------------------------------------------------
// stl_pkg - shared types and constants of the script token lexer
// Item and result payloads, token kinds, error codes, lexer modes and the
// character codes that the lexer looks for.
// ----------------------------------------------------------------------------
`default_nettype none

package stl_pkg;

    // One input item: a program byte or the end-of-program mark
    typedef struct packed {
        logic       kind;
        logic [7:0] char_byte;
    } item_t;

    // One result item
    typedef struct packed {
        logic [3:0]  token_kind;
        logic [7:0]  text_byte;
        logic [31:0] int_magnitude;
        logic [59:0] frac_value;
        logic [4:0]  frac_count;
        logic        negative;
        logic [15:0] text_length;
        logic [1:0]  error_code;
        logic        last;
    } result_t;

    // Most results one item can cause
    localparam int MAX_RESULTS = 4;
    localparam int RES_CNT_BITS = $clog2(MAX_RESULTS + 1);

    // Results of one lexer step, handed to the result queue
    typedef struct packed {
        logic [RES_CNT_BITS-1:0]  count;
        result_t [MAX_RESULTS-1:0] res;
    } step_out_t;

    // Result queue depth
    localparam int QUEUE_DEPTH = 8;

    // Input item kinds
    localparam logic ITEM_BYTE = 1'b0;
    localparam logic ITEM_END  = 1'b1;

    // Token kinds
    localparam logic [3:0] TK_BEGIN   = 4'd0;
    localparam logic [3:0] TK_INT     = 4'd1;
    localparam logic [3:0] TK_DEC     = 4'd2;
    localparam logic [3:0] TK_IDENT   = 4'd3;
    localparam logic [3:0] TK_STR     = 4'd4;
    localparam logic [3:0] TK_OPER    = 4'd5;
    localparam logic [3:0] TK_LPAREN  = 4'd6;
    localparam logic [3:0] TK_RPAREN  = 4'd7;
    localparam logic [3:0] TK_LBRACE  = 4'd8;
    localparam logic [3:0] TK_RBRACE  = 4'd9;
    localparam logic [3:0] TK_COMMA   = 4'd10;
    localparam logic [3:0] TK_SEMI    = 4'd11;
    localparam logic [3:0] TK_CONTENT = 4'd12;
    localparam logic [3:0] TK_END     = 4'd13;
    localparam logic [3:0] TK_DROP    = 4'd14;

    // Error codes
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_UNTERM   = 2'd1;
    localparam logic [1:0] ERR_STRAY_US = 2'd2;

    // Lexer modes
    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_INT,
        MODE_FRAC,
        MODE_IDENT,
        MODE_STR,
        MODE_OPER
    } lex_mode_t;

    // Character codes
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_Z   = 8'h5A;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_Z   = 8'h7A;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

endpackage

`default_nettype wire

// File: design/stl_core.sv
// ----------------------------------------------------------------------------
// stl_core - lexer state and per-item step logic
// Holds the lexer state and, for each registered item, works out the next
// state and the list of up to four results in one pass.
// ----------------------------------------------------------------------------
`default_nettype none

module stl_core #(
    parameter int MAX_FRAC_DIGITS = 18,
    parameter int LENGTH_BITS     = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  stl_pkg::item_t    item,
    output stl_pkg::step_out_t step_out
);
    import stl_pkg::*;

    // Lexer state
    lex_mode_t               mode_reg,       mode_next;
    logic [31:0]             int_accum_reg,  int_accum_next;
    logic [59:0]             frac_accum_reg, frac_accum_next;
    logic [4:0]              frac_seen_reg,  frac_seen_next;
    logic [LENGTH_BITS-1:0]  text_count_reg, text_count_next;
    logic [7:0]              held_char_reg,  held_char_next;
    logic                    held_valid_reg, held_valid_next;
    logic                    after_op_reg,   after_op_next;
    logic                    neg_pend_reg,   neg_pend_next;
    logic                    started_reg,    started_next;

    // Byte classes
    logic [7:0]  c;
    logic        is_end;
    logic        is_digit, is_letter, is_ws, is_punct, op_stop;
    logic [3:0]  punct_kind;
    logic        cont;
    logic        lone_minus;

    // Arithmetic
    logic [31:0]            int_x10;
    logic [59:0]            frac_x10;
    logic [LENGTH_BITS-1:0] text_inc;
    logic [15:0]            text_len;

    function automatic result_t mk_res(input logic [3:0]  kind,
                                       input logic [7:0]  tbyte,
                                       input logic [31:0] mag,
                                       input logic [59:0] frac,
                                       input logic [4:0]  fcount,
                                       input logic        neg,
                                       input logic [15:0] len,
                                       input logic [1:0]  err);
        result_t r;
        r.token_kind    = kind;
        r.text_byte     = tbyte;
        r.int_magnitude = mag;
        r.frac_value    = frac;
        r.frac_count    = fcount;
        r.negative      = neg;
        r.text_length   = len;
        r.error_code    = err;
        r.last          = 1'b0;
        return r;
    endfunction

    // Byte decode
    always_comb
    begin
        c         = item.char_byte;
        is_end    = (item.kind == ITEM_END);
        is_digit  = (c >= CH_0) && (c <= CH_9);
        is_letter = ((c >= CH_LO_A) && (c <= CH_LO_Z)) ||
                    ((c >= CH_UP_A) && (c <= CH_UP_Z));
        is_ws     = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) ||
                    (c == CH_CR) || (c == CH_NUL);
        is_punct  = (c == CH_LPAREN) || (c == CH_RPAREN) || (c == CH_LBRACE) ||
                    (c == CH_RBRACE) || (c == CH_COMMA) || (c == CH_SEMI);
        op_stop   = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LBRACE) ||
                    (c == CH_LPAREN) || (c == CH_QUOTE) || (c == CH_LF) ||
                    is_digit || is_letter || (c == CH_UNDER) || (c == CH_NUL);
        unique case (c)
            CH_LPAREN: punct_kind = TK_LPAREN;
            CH_RPAREN: punct_kind = TK_RPAREN;
            CH_LBRACE: punct_kind = TK_LBRACE;
            CH_RBRACE: punct_kind = TK_RBRACE;
            CH_COMMA:  punct_kind = TK_COMMA;
            default:   punct_kind = TK_SEMI;
        endcase
    end

    // Does this byte continue the open token
    always_comb
    begin
        unique case (mode_reg)
            MODE_INT:   cont = is_digit || (c == CH_DOT);
            MODE_FRAC:  cont = is_digit;
            MODE_IDENT: cont = is_letter || is_digit || (c == CH_UNDER);
            MODE_STR:   cont = 1'b1;
            MODE_OPER:  cont = !op_stop;
            default:    cont = 1'b0;
        endcase
    end

    // Shift-add by ten, saturating length count
    assign int_x10    = (int_accum_reg << 3) + (int_accum_reg << 1) + 32'(c[3:0]);
    assign frac_x10   = (frac_accum_reg << 3) + (frac_accum_reg << 1) + 60'(c[3:0]);
    assign text_inc   = (text_count_reg == '1) ? text_count_reg
                                               : text_count_reg + LENGTH_BITS'(1);
    assign text_len   = 16'(text_count_reg);
    assign lone_minus = held_valid_reg && (held_char_reg == CH_MINUS) && after_op_reg;

    // Next state
    always_comb
    begin
        mode_next       = mode_reg;
        int_accum_next  = int_accum_reg;
        frac_accum_next = frac_accum_reg;
        frac_seen_next  = frac_seen_reg;
        text_count_next = text_count_reg;
        held_char_next  = held_char_reg;
        held_valid_next = held_valid_reg;
        after_op_next   = after_op_reg;
        neg_pend_next   = neg_pend_reg;
        started_next    = 1'b1;

        if (is_end) begin
            mode_next       = MODE_IDLE;
            int_accum_next  = '0;
            frac_accum_next = '0;
            frac_seen_next  = '0;
            text_count_next = '0;
            held_char_next  = '0;
            held_valid_next = 1'b0;
            after_op_next   = 1'b1;
            neg_pend_next   = 1'b0;
            started_next    = 1'b0;
        end else if (cont) begin
            unique case (mode_reg)
                MODE_INT:
                begin
                    if (is_digit)
                        int_accum_next = int_x10;
                    else
                        mode_next = MODE_FRAC;
                end
                MODE_FRAC:
                begin
                    if (frac_seen_reg < 5'(MAX_FRAC_DIGITS)) begin
                        frac_accum_next = frac_x10;
                        frac_seen_next  = frac_seen_reg + 5'd1;
                    end
                end
                MODE_STR:
                begin
                    if (c == CH_QUOTE) begin
                        after_op_next   = 1'b0;
                        mode_next       = MODE_IDLE;
                        text_count_next = '0;
                    end else begin
                        text_count_next = text_inc;
                    end
                end
                MODE_OPER:
                begin
                    held_valid_next = 1'b0;
                    text_count_next = text_inc;
                end
                default:
                begin
                    text_count_next = text_inc;
                end
            endcase
        end else begin
            // finish the open token
            unique case (mode_reg)
                MODE_INT, MODE_FRAC:
                begin
                    neg_pend_next = 1'b0;
                    after_op_next = 1'b0;
                end
                MODE_IDENT:
                begin
                    after_op_next = 1'b0;
                end
                MODE_OPER:
                begin
                    if (lone_minus)
                        neg_pend_next = 1'b1;
                    else
                        after_op_next = 1'b1;
                end
                default:
                begin
                end
            endcase
            held_valid_next = 1'b0;
            mode_next       = MODE_IDLE;
            int_accum_next  = '0;
            frac_accum_next = '0;
            frac_seen_next  = '0;
            text_count_next = '0;

            // start on this byte
            if (is_digit) begin
                mode_next      = MODE_INT;
                int_accum_next = 32'(c[3:0]);
            end else if (is_letter) begin
                mode_next       = MODE_IDENT;
                text_count_next = LENGTH_BITS'(1);
            end else if (c == CH_QUOTE) begin
                mode_next = MODE_STR;
            end else if (is_punct) begin
                after_op_next = 1'b1;
            end else if (is_ws || (c == CH_UNDER)) begin
                mode_next = MODE_IDLE;
            end else begin
                mode_next       = MODE_OPER;
                held_char_next  = c;
                held_valid_next = 1'b1;
                text_count_next = LENGTH_BITS'(1);
            end
        end
    end

    // Result list
    always_comb
    begin
        logic [RES_CNT_BITS-1:0] n;
        result_t [MAX_RESULTS-1:0] res;
        n   = '0;
        res = '0;

        if (!started_reg) begin
            res[n[1:0]] = mk_res(TK_BEGIN, '0, '0, '0, '0, 1'b0, '0, ERR_NONE);
            n = n + RES_CNT_BITS'(1);
        end

        if (!is_end && cont) begin
            unique case (mode_reg)
                MODE_IDENT:
                begin
                    res[n[1:0]] = mk_res(TK_CONTENT, c, '0, '0, '0, 1'b0, '0, ERR_NONE);
                    n = n + RES_CNT_BITS'(1);
                end
                MODE_STR:
                begin
                    if (c == CH_QUOTE)
                        res[n[1:0]] = mk_res(TK_STR, '0, '0, '0, '0, 1'b0, text_len,
                                             ERR_NONE);
                    else
                        res[n[1:0]] = mk_res(TK_CONTENT, c, '0, '0, '0, 1'b0, '0,
                                             ERR_NONE);
                    n = n + RES_CNT_BITS'(1);
                end
                MODE_OPER:
                begin
                    if (held_valid_reg) begin
                        res[n[1:0]] = mk_res(TK_CONTENT, held_char_reg, '0, '0, '0,
                                             1'b0, '0, ERR_NONE);
                        n = n + RES_CNT_BITS'(1);
                    end
                    res[n[1:0]] = mk_res(TK_CONTENT, c, '0, '0, '0, 1'b0, '0, ERR_NONE);
                    n = n + RES_CNT_BITS'(1);
                end
                default:
                begin
                end
            endcase
        end else begin
            // finish the open token
            unique case (mode_reg)
                MODE_INT:
                begin
                    res[n[1:0]] = mk_res(TK_INT, '0, int_accum_reg, '0, '0,
                                         neg_pend_reg, '0, ERR_NONE);
                    n = n + RES_CNT_BITS'(1);
                end
                MODE_FRAC:
                begin
                    res[n[1:0]] = mk_res(TK_DEC, '0, int_accum_reg, frac_accum_reg,
                                         frac_seen_reg, neg_pend_reg, '0, ERR_NONE);
                    n = n + RES_CNT_BITS'(1);
                end
                MODE_IDENT:
                begin
                    res[n[1:0]] = mk_res(TK_IDENT, '0, '0, '0, '0, 1'b0, text_len,
                                         ERR_NONE);
                    n = n + RES_CNT_BITS'(1);
                end
                MODE_STR:
                begin
                    if (is_end) begin
                        res[n[1:0]] = mk_res(TK_STR, '0, '0, '0, '0, 1'b0, text_len,
                                             ERR_UNTERM);
                        n = n + RES_CNT_BITS'(1);
                    end
                end
                MODE_OPER:
                begin
                    if (!lone_minus) begin
                        if (held_valid_reg) begin
                            res[n[1:0]] = mk_res(TK_CONTENT, held_char_reg, '0, '0, '0,
                                                 1'b0, '0, ERR_NONE);
                            n = n + RES_CNT_BITS'(1);
                        end
                        res[n[1:0]] = mk_res(TK_OPER, '0, '0, '0, '0, 1'b0, text_len,
                                             ERR_NONE);
                        n = n + RES_CNT_BITS'(1);
                    end
                end
                default:
                begin
                end
            endcase

            // end mark, or the results of starting on this byte
            if (is_end) begin
                res[n[1:0]] = mk_res(TK_END, '0, '0, '0, '0, 1'b0, '0, ERR_NONE);
                n = n + RES_CNT_BITS'(1);
            end else if (is_digit) begin
                n = n;
            end else if (is_letter) begin
                res[n[1:0]] = mk_res(TK_CONTENT, c, '0, '0, '0, 1'b0, '0, ERR_NONE);
                n = n + RES_CNT_BITS'(1);
            end else if (is_punct) begin
                res[n[1:0]] = mk_res(punct_kind, '0, '0, '0, '0, 1'b0, '0, ERR_NONE);
                n = n + RES_CNT_BITS'(1);
            end else if (c == CH_UNDER) begin
                res[n[1:0]] = mk_res(TK_DROP, '0, '0, '0, '0, 1'b0, '0, ERR_STRAY_US);
                n = n + RES_CNT_BITS'(1);
            end
        end

        // mark the final result of this item
        if (n != '0)
            res[2'(n - RES_CNT_BITS'(1))].last = 1'b1;

        step_out.count = n;
        step_out.res   = res;
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg       <= MODE_IDLE;
            int_accum_reg  <= '0;
            frac_accum_reg <= '0;
            frac_seen_reg  <= '0;
            text_count_reg <= '0;
            held_char_reg  <= '0;
            held_valid_reg <= 1'b0;
            after_op_reg   <= 1'b1;
            neg_pend_reg   <= 1'b0;
            started_reg    <= 1'b0;
        end else if (step) begin
            mode_reg       <= mode_next;
            int_accum_reg  <= int_accum_next;
            frac_accum_reg <= frac_accum_next;
            frac_seen_reg  <= frac_seen_next;
            text_count_reg <= text_count_next;
            held_char_reg  <= held_char_next;
            held_valid_reg <= held_valid_next;
            after_op_reg   <= after_op_next;
            neg_pend_reg   <= neg_pend_next;
            started_reg    <= started_next;
        end
    end

endmodule

`default_nettype wire

// File: design/stl_queue.sv
// ----------------------------------------------------------------------------
// stl_queue - result queue
// Takes up to four results per cycle from the lexer step and hands them
// out one per transfer on the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module stl_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  stl_pkg::step_out_t step_out,
    output logic               room,
    output logic               result_valid,
    input  logic               result_stall,
    output stl_pkg::result_t   result
);
    import stl_pkg::*;

    localparam int IDX_BITS = $clog2(QUEUE_DEPTH);
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    result_t [QUEUE_DEPTH-1:0] entry_reg;
    logic [IDX_BITS-1:0]       head_reg, head_next;
    logic [IDX_BITS-1:0]       tail_reg, tail_next;
    logic [CNT_BITS-1:0]       count_reg, count_next;
    logic [CNT_BITS-1:0]       push_n;
    logic                      pop;

    // Room for a full step's worth of results
    assign room         = (count_reg <= CNT_BITS'(QUEUE_DEPTH - MAX_RESULTS));
    assign result_valid = (count_reg != '0);
    assign result       = entry_reg[head_reg];
    assign pop          = result_valid && !result_stall;
    assign push_n       = push ? CNT_BITS'(step_out.count) : '0;

    // Pointer and fill level update
    always_comb
    begin
        tail_next  = tail_reg + IDX_BITS'(push_n);
        head_next  = pop ? head_reg + IDX_BITS'(1) : head_reg;
        count_next = count_reg + push_n - CNT_BITS'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // Entry writes, one per result of the step
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_RESULTS; i++) begin
            if (push && (RES_CNT_BITS'(i) < step_out.count))
                entry_reg[tail_reg + IDX_BITS'(i)] <= step_out.res[i];
        end
    end

endmodule

`default_nettype wire

// File: design/script_token_lexer.sv
// ----------------------------------------------------------------------------
// script_token_lexer - streaming lexer for a small script language
// Turns a stream of program bytes into begin, content-byte, token and end
// results, numbers carried as integer part plus decimal fraction digits.
// ----------------------------------------------------------------------------
//
//  channel  | ports                              | direction
//  ---------+------------------------------------+----------
//  item     | item, item_valid, item_stall       | in
//  result   | result, result_valid, result_stall | out
//
//  An item is registered on transfer and lexed once the queue has room, when
//  its zero to four results are written into an eight-entry result queue.
//  One item per cycle is taken while the queue has room for four results;
//  results leave at one per cycle while result_stall is low, so the queue
//  drain rate sets the long-run rate when items cause over one result each.
//  Reset returns the lexer to the start of a program with an empty queue.
//  item_stall is high while a registered item waits for queue room.
// ----------------------------------------------------------------------------
`default_nettype none

module script_token_lexer #(
    parameter int MAX_FRAC_DIGITS = 18,
    parameter int LENGTH_BITS     = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  stl_pkg::item_t   item,
    input  logic             item_valid,
    output logic             item_stall,
    output stl_pkg::result_t result,
    output logic             result_valid,
    input  logic             result_stall
);
    import stl_pkg::*;

    item_t     item_reg;
    logic      item_full_reg, item_full_next;
    logic      room;
    logic      step;
    step_out_t step_out;

    // Input register: emptied when the queue can take a full step
    assign step           = item_full_reg && room;
    assign item_stall     = item_full_reg && !room;
    assign item_full_next = (item_valid && !item_stall) ? 1'b1 :
                            step ? 1'b0 : item_full_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_full_reg <= 1'b0;
        else
            item_full_reg <= item_full_next;
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
            item_reg <= item;
    end

    // Lexer step
    stl_core #(
        .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS),
        .LENGTH_BITS     (LENGTH_BITS)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .item     (item_reg),
        .step_out (step_out)
    );

    // Result queue
    stl_queue u_queue (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (step),
        .step_out     (step_out),
        .room         (room),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

`default_nettype wire

// File: tb/script_token_lexer_tb.sv
// ----------------------------------------------------------------------------
// script_token_lexer_tb - self-checking bench for the script token lexer
// Feeds short hand-written programs, then random well-formed programs mixed
// with noise, with bursty input and a stalling receiver. A built-in lexer
// model predicts every result, which is checked field by field against the
// result channel in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module script_token_lexer_tb;

    import stl_pkg::*;

    localparam int FRAC_LIMIT = 18;
    localparam int LEN_BITS   = 16;
    localparam int unsigned LEN_MAX = (1 << LEN_BITS) - 1;

    logic    clk;
    logic    rst_n        = 1'b0;
    item_t   item         = '0;
    logic    item_valid   = 1'b0;
    logic    item_stall;
    result_t result;
    logic    result_valid;
    logic    result_stall = 1'b0;

    script_token_lexer #(
        .MAX_FRAC_DIGITS(FRAC_LIMIT),
        .LENGTH_BITS    (LEN_BITS)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .result      (result),
        .result_valid(result_valid),
        .result_stall(result_stall)
    );

    // Stimulus and expected results
    item_t   byte_feed[$];
    result_t expected_tokens[$];
    result_t step_tokens[$];
    int      mismatches = 0;
    int      results_seen = 0;

    // Lexer model state
    lex_mode_t   lex_mode_q;
    logic [31:0] whole_part;
    logic [59:0] frac_part;
    logic [4:0]  frac_digits;
    int unsigned text_len;
    logic [7:0]  held_byte;
    bit          held_ok;
    bit          after_op;
    bit          negate_next;
    bit          in_program;

    // Driver and receiver pacing
    int burst_left = 0;
    int gap_left = 0;
    int stall_style = 0;
    int stall_phase_left = 0;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Lexer model
    // ------------------------------------------------------------------------
    function automatic bit is_digit(logic [7:0] c);
        return c >= CH_0 && c <= CH_9;
    endfunction

    function automatic bit is_letter(logic [7:0] c);
        return (c >= CH_LO_A && c <= CH_LO_Z) || (c >= CH_UP_A && c <= CH_UP_Z);
    endfunction

    task automatic add_token(logic [3:0] kind, logic [7:0] b, logic [31:0] mag,
                             logic [59:0] frac, logic [4:0] fcnt, bit neg,
                             int unsigned len, logic [1:0] err);
        result_t r;
        if (step_tokens.size() < MAX_RESULTS)
        begin
            r.token_kind    = kind;
            r.text_byte     = b;
            r.int_magnitude = mag;
            r.frac_value    = frac;
            r.frac_count    = fcnt;
            r.negative      = neg;
            r.text_length   = 16'(len);
            r.error_code    = err;
            r.last          = 1'b0;
            step_tokens.push_back(r);
        end
    endtask

    task automatic add_plain(logic [3:0] kind, logic [7:0] b, int unsigned len,
                             logic [1:0] err);
        add_token(kind, b, '0, '0, '0, 1'b0, len, err);
    endtask

    task automatic bump_length();
        if (text_len < LEN_MAX)
            text_len++;
    endtask

    task automatic restart_program();
        lex_mode_q  = MODE_IDLE;
        whole_part  = '0;
        frac_part   = '0;
        frac_digits = '0;
        text_len    = 0;
        held_byte   = '0;
        held_ok     = 1'b0;
        after_op    = 1'b1;
        negate_next = 1'b0;
        in_program  = 1'b0;
    endtask

    // Finish whatever token is open
    task automatic close_token(bit at_end);
        case (lex_mode_q)
            MODE_INT:
            begin
                add_token(TK_INT, '0, whole_part, '0, '0, negate_next, 0, ERR_NONE);
                negate_next = 1'b0;
                after_op    = 1'b0;
            end
            MODE_FRAC:
            begin
                add_token(TK_DEC, '0, whole_part, frac_part, frac_digits, negate_next,
                          0, ERR_NONE);
                negate_next = 1'b0;
                after_op    = 1'b0;
            end
            MODE_IDENT:
            begin
                add_plain(TK_IDENT, '0, text_len, ERR_NONE);
                after_op = 1'b0;
            end
            MODE_STR:
            begin
                if (at_end)
                begin
                    add_plain(TK_STR, '0, text_len, ERR_UNTERM);
                    after_op = 1'b0;
                end
            end
            MODE_OPER:
            begin
                // a lone minus after an operator only negates the next number
                if (held_ok && held_byte == CH_MINUS && after_op)
                    negate_next = 1'b1;
                else
                begin
                    if (held_ok)
                        add_plain(TK_CONTENT, held_byte, 0, ERR_NONE);
                    add_plain(TK_OPER, '0, text_len, ERR_NONE);
                    after_op = 1'b1;
                end
                held_ok = 1'b0;
            end
            default: ;
        endcase
        lex_mode_q  = MODE_IDLE;
        whole_part  = '0;
        frac_part   = '0;
        frac_digits = '0;
        text_len    = 0;
    endtask

    // Lex one accepted item and queue the results it causes
    task automatic lex_step(item_t it);
        logic [7:0] c;
        logic [3:0] punct;
        bit         restart;
        bit         stopper;
        c = it.char_byte;
        step_tokens.delete();
        if (!in_program)
        begin
            add_plain(TK_BEGIN, '0, 0, ERR_NONE);
            in_program = 1'b1;
        end
        if (it.kind == ITEM_END)
        begin
            close_token(1'b1);
            add_plain(TK_END, '0, 0, ERR_NONE);
            restart_program();
        end
        else
        begin
            restart = 1'b1;
            stopper = c == CH_SPACE || c == CH_TAB || c == CH_LBRACE || c == CH_LPAREN ||
                      c == CH_QUOTE || c == CH_LF || is_digit(c) || is_letter(c) ||
                      c == CH_UNDER || c == CH_NUL;
            // continue the open token where the byte fits it
            case (lex_mode_q)
                MODE_INT:
                begin
                    if (is_digit(c))
                    begin
                        whole_part = whole_part * 32'd10 + 32'(c - CH_0);
                        restart    = 1'b0;
                    end
                    else if (c == CH_DOT)
                    begin
                        lex_mode_q = MODE_FRAC;
                        restart    = 1'b0;
                    end
                end
                MODE_FRAC:
                begin
                    if (is_digit(c))
                    begin
                        if (frac_digits < FRAC_LIMIT)
                        begin
                            frac_part = frac_part * 60'd10 + 60'(c - CH_0);
                            frac_digits++;
                        end
                        restart = 1'b0;
                    end
                end
                MODE_IDENT:
                begin
                    if (is_letter(c) || is_digit(c) || c == CH_UNDER)
                    begin
                        add_plain(TK_CONTENT, c, 0, ERR_NONE);
                        bump_length();
                        restart = 1'b0;
                    end
                end
                MODE_STR:
                begin
                    if (c == CH_QUOTE)
                    begin
                        add_plain(TK_STR, '0, text_len, ERR_NONE);
                        after_op   = 1'b0;
                        lex_mode_q = MODE_IDLE;
                        text_len   = 0;
                    end
                    else
                    begin
                        add_plain(TK_CONTENT, c, 0, ERR_NONE);
                        bump_length();
                    end
                    restart = 1'b0;
                end
                MODE_OPER:
                begin
                    if (!stopper)
                    begin
                        if (held_ok)
                        begin
                            add_plain(TK_CONTENT, held_byte, 0, ERR_NONE);
                            held_ok = 1'b0;
                        end
                        add_plain(TK_CONTENT, c, 0, ERR_NONE);
                        bump_length();
                        restart = 1'b0;
                    end
                end
                default: ;
            endcase

            // otherwise close it and let the byte start something new
            if (restart)
            begin
                close_token(1'b0);
                if (is_digit(c))
                begin
                    lex_mode_q = MODE_INT;
                    whole_part = 32'(c - CH_0);
                end
                else if (is_letter(c))
                begin
                    lex_mode_q = MODE_IDENT;
                    text_len   = 1;
                    add_plain(TK_CONTENT, c, 0, ERR_NONE);
                end
                else if (c == CH_QUOTE)
                begin
                    lex_mode_q = MODE_STR;
                    text_len   = 0;
                end
                else if (c == CH_LPAREN || c == CH_RPAREN || c == CH_LBRACE ||
                         c == CH_RBRACE || c == CH_COMMA || c == CH_SEMI)
                begin
                    case (c)
                        CH_LPAREN: punct = TK_LPAREN;
                        CH_RPAREN: punct = TK_RPAREN;
                        CH_LBRACE: punct = TK_LBRACE;
                        CH_RBRACE: punct = TK_RBRACE;
                        CH_COMMA:  punct = TK_COMMA;
                        default:   punct = TK_SEMI;
                    endcase
                    add_plain(punct, '0, 0, ERR_NONE);
                    after_op = 1'b1;
                end
                else if (c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR ||
                         c == CH_NUL)
                begin
                    // whitespace and zero bytes are skipped
                end
                else if (c == CH_UNDER)
                    add_plain(TK_DROP, '0, 0, ERR_STRAY_US);
                else
                begin
                    lex_mode_q = MODE_OPER;
                    held_byte  = c;
                    held_ok    = 1'b1;
                    text_len   = 1;
                end
            end
        end
        if (step_tokens.size() > 0)
            step_tokens[step_tokens.size() - 1].last = 1'b1;
        foreach (step_tokens[i])
            expected_tokens.push_back(step_tokens[i]);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------------
    task automatic push_byte(logic [7:0] b);
        item_t it;
        it.kind      = ITEM_BYTE;
        it.char_byte = b;
        byte_feed.push_back(it);
    endtask

    task automatic push_end();
        item_t it;
        it.kind      = ITEM_END;
        it.char_byte = 8'($urandom_range(0, 255));
        byte_feed.push_back(it);
    endtask

    task automatic push_text(string s);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i]);
    endtask

    function automatic logic [7:0] ws_byte();
        case ($urandom_range(0, 4))
            0:       return CH_TAB;
            1:       return CH_LF;
            2:       return CH_CR;
            3:       return CH_NUL;
            default: return CH_SPACE;
        endcase
    endfunction

    function automatic logic [7:0] punct_byte();
        case ($urandom_range(0, 5))
            0:       return CH_LPAREN;
            1:       return CH_RPAREN;
            2:       return CH_LBRACE;
            3:       return CH_RBRACE;
            4:       return CH_COMMA;
            default: return CH_SEMI;
        endcase
    endfunction

    function automatic logic [7:0] letter_byte();
        if ($urandom_range(0, 1) == 0)
            return CH_LO_A + 8'($urandom_range(0, 25));
        return CH_UP_A + 8'($urandom_range(0, 25));
    endfunction

    // Operator bytes; inside a run a few punctuation and CR bytes also fit
    function automatic logic [7:0] op_byte(bit inner);
        string op_chars;
        op_chars = "+-*/=<>!&|%^~@#$?:";
        case ($urandom_range(0, 6))
            0: return 8'($urandom_range(8'h80, 8'hFF));
            1: return 8'($urandom_range(1, 8));
            2:
            begin
                if (!inner)
                    return 8'($urandom_range(8'h0E, 8'h1F));
                case ($urandom_range(0, 5))
                    0:       return CH_CR;
                    1:       return CH_RPAREN;
                    2:       return CH_RBRACE;
                    3:       return CH_COMMA;
                    4:       return CH_SEMI;
                    default: return CH_DOT;
                endcase
            end
            3: return CH_MINUS;
            default: return op_chars[$urandom_range(0, op_chars.len() - 1)];
        endcase
    endfunction

    // Integer or decimal, now and then long enough to wrap or cut the fraction
    task automatic add_number();
        int n;
        n = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 4);
        for (int i = 0; i < n; i++)
            push_byte(CH_0 + 8'($urandom_range(0, 9)));
        if ($urandom_range(0, 1) == 0)
        begin
            push_byte(CH_DOT);
            n = ($urandom_range(0, 4) == 0) ? $urandom_range(16, 22)
                                            : $urandom_range(0, 4);
            for (int i = 0; i < n; i++)
                push_byte(CH_0 + 8'($urandom_range(0, 9)));
        end
    endtask

    task automatic add_random_program();
        int n_tok;
        int n;
        logic [7:0] b;
        n_tok = $urandom_range(1, 14);
        for (int t = 0; t < n_tok; t++)
        begin
            case ($urandom_range(0, 11))
                0, 1: add_number();
                2:
                begin
                    // negated number after punctuation or an operator
                    if ($urandom_range(0, 1) == 0)
                        push_byte(punct_byte());
                    else
                    begin
                        push_byte(op_byte(1'b0));
                        push_byte(CH_SPACE);
                    end
                    push_byte(CH_MINUS);
                    add_number();
                end
                3, 4:
                begin
                    push_byte(letter_byte());
                    n = $urandom_range(0, 8);
                    for (int i = 0; i < n; i++)
                    begin
                        case ($urandom_range(0, 3))
                            0:       push_byte(CH_0 + 8'($urandom_range(0, 9)));
                            1:       push_byte(CH_UNDER);
                            default: push_byte(letter_byte());
                        endcase
                    end
                end
                5:
                begin
                    push_byte(CH_QUOTE);
                    n = $urandom_range(0, 8);
                    for (int i = 0; i < n; i++)
                    begin
                        b = 8'($urandom_range(0, 255));
                        push_byte(b == CH_QUOTE ? CH_NUL : b);
                    end
                    push_byte(CH_QUOTE);
                end
                6:
                begin
                    push_byte(op_byte(1'b0));
                    n = $urandom_range(0, 3);
                    for (int i = 0; i < n; i++)
                        push_byte(op_byte(1'b1));
                end
                7: push_byte(punct_byte());
                8: push_byte(ws_byte());
                9: push_byte(8'($urandom_range(0, 255)));
                10: push_byte(CH_UNDER);
                default:
                begin
                    // negation carried across an identifier to a later number
                    push_byte(CH_COMMA);
                    push_byte(CH_MINUS);
                    push_byte(letter_byte());
                    push_byte(CH_SPACE);
                    add_number();
                end
            endcase
            if ($urandom_range(0, 2) == 0)
                push_byte(ws_byte());
        end
        // now and then leave a string open at the end
        if ($urandom_range(0, 9) == 0)
        begin
            push_byte(CH_QUOTE);
            push_byte(8'($urandom_range(0, 255)) & 8'hDD);
        end
        push_end();
    endtask

    // ------------------------------------------------------------------------
    // Driver: bursts of transfers with random gaps
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            item       <= '0;
        end
        else if (!item_valid || !item_stall)
        begin
            if (item_valid)
                lex_step(item);
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 24);
                gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end
            if (gap_left > 0 || byte_feed.size() == 0)
            begin
                item_valid <= 1'b0;
                if (gap_left > 0)
                    gap_left--;
            end
            else
            begin
                item       <= byte_feed.pop_front();
                item_valid <= 1'b1;
                burst_left--;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver stall: phases of no stall, light, periodic and heavy stalling
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_stall <= 1'b0;
        else
        begin
            if (stall_phase_left == 0)
            begin
                stall_style      = $urandom_range(0, 3);
                stall_phase_left = $urandom_range(20, 150);
            end
            else
                stall_phase_left--;
            case (stall_style)
                0:       result_stall <= 1'b0;
                1:       result_stall <= ($urandom_range(0, 3) == 0);
                2:       result_stall <= (stall_phase_left % 3 == 0);
                default: result_stall <= ($urandom_range(0, 1) == 1);
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: compare each result transfer with the oldest expectation
    // ------------------------------------------------------------------------
    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        mismatches++;
        if (mismatches <= 30)
            $display("MISMATCH at result %0d, %0s: got 0x%0h, expected 0x%0h",
                     results_seen, what, got, want);
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_tokens.size() == 0)
                report_mismatch("unexpected result, token_kind",
                                64'(result.token_kind), '0);
            else
            begin
                want = expected_tokens.pop_front();
                if (result.token_kind !== want.token_kind)
                    report_mismatch("token_kind", 64'(result.token_kind),
                                    64'(want.token_kind));
                if (result.text_byte !== want.text_byte)
                    report_mismatch("text_byte", 64'(result.text_byte),
                                    64'(want.text_byte));
                if (result.int_magnitude !== want.int_magnitude)
                    report_mismatch("int_magnitude", 64'(result.int_magnitude),
                                    64'(want.int_magnitude));
                if (result.frac_value !== want.frac_value)
                    report_mismatch("frac_value", 64'(result.frac_value),
                                    64'(want.frac_value));
                if (result.frac_count !== want.frac_count)
                    report_mismatch("frac_count", 64'(result.frac_count),
                                    64'(want.frac_count));
                if (result.negative !== want.negative)
                    report_mismatch("negative", 64'(result.negative),
                                    64'(want.negative));
                if (result.text_length !== want.text_length)
                    report_mismatch("text_length", 64'(result.text_length),
                                    64'(want.text_length));
                if (result.error_code !== want.error_code)
                    report_mismatch("error_code", 64'(result.error_code),
                                    64'(want.error_code));
                if (result.last !== want.last)
                    report_mismatch("last", 64'(result.last), 64'(want.last));
            end
            results_seen++;
        end
    end

    // ------------------------------------------------------------------------
    // Sequence: build stimulus, reset, run, drain
    // ------------------------------------------------------------------------
    initial
    begin
        int target;
        restart_program();

        // Stray underscore, ident, lone minus negating a decimal without
        // fraction digits, unterminated string holding a zero byte
        push_text("_a1_(-7.;\"x");
        push_byte(CH_NUL);
        push_end();
        // Empty program
        push_end();
        // Punctuation, operator run with top byte, CR and dot inside, int at end
        push_text(")}{,");
        push_byte(8'hFF);
        push_byte(CH_CR);
        push_byte(CH_DOT);
        push_byte(CH_TAB);
        push_text("9");
        push_end();

        // Random programs
        target = byte_feed.size() + 230;
        while (byte_feed.size() < target)
            add_random_program();

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (byte_feed.size() != 0 || item_valid)
            @(posedge clk);
        while (expected_tokens.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);

        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog
    initial
    begin
        #25_000_000;
        $display("TIMEOUT with %0d results still expected", expected_tokens.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule
